// ===== src/ntc_beta_temperature_macros.svh =====
// Assertion helpers for the converter top level.
`ifndef NTC_BETA_TEMPERATURE_MACROS_SVH
`define NTC_BETA_TEMPERATURE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define NTC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ntc assertion failed");

// Next-cycle implication, checked out of reset.
`define NTC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ntc assertion failed");

`endif

// ===== src/ntc_pkg.sv =====
// ----------------------------------------------------------------------------
// ntc_pkg
// Widths, codes and shared types of the thermistor temperature converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package ntc_pkg;

  localparam int SampleW   = 13;
  localparam int TempW     = 19;
  localparam int StatusW   = 2;
  localparam int CfgIdxW   = 3;
  localparam int CfgDataW  = 24;
  localparam int PullupW   = 20;
  localparam int PulldownW = 20;
  localparam int SupplyW   = 13;
  localparam int NominalW  = 24;
  localparam int BetaW     = 14;
  localparam int LimitW    = 13;

  localparam int LnInW = 34;   // log unit operand
  localparam int LnW   = 21;   // Q16 log result
  localparam int LqW   = 23;   // signed log difference
  localparam int DW    = 40;   // signed denominator
  localparam int M3W   = 36;   // 2981500 * beta
  localparam int NumW  = 54;   // divider numerator
  localparam int QW    = 18;   // quotient bits

  localparam logic [CfgIdxW-1:0] REG_PULLUP   = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_PULLDOWN = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SUPPLY   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_NOMINAL  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_BETA     = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LOW      = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_HIGH     = 3'd6;

  localparam logic [StatusW-1:0] ST_OK    = 2'd0;
  localparam logic [StatusW-1:0] ST_LIMIT = 2'd1;
  localparam logic [StatusW-1:0] ST_RES   = 2'd2;

  localparam logic signed [TempW-1:0] TEMP_LIMIT = -19'sd9900;
  localparam logic signed [TempW-1:0] TEMP_TOP   = 19'sd200000;
  localparam logic signed [TempW-1:0] TEMP_ZERO  = 19'sd0;
  localparam logic signed [QW+1:0]    KELVIN_OFS = 20'sd27315;
  localparam logic [63:0]             LN2_Q32    = 64'd2977044472;

  typedef struct packed {
    logic [PullupW-1:0]   pullup_ohms;
    logic [PulldownW-1:0] pulldown_ohms;
    logic [SupplyW-1:0]   supply_mv;
    logic [LimitW-1:0]    low_limit_mv;
    logic [LimitW-1:0]    high_limit_mv;
  } cfg_t;

  typedef struct packed {
    logic [LnInW-1:0]   rn_mag;
    logic [SampleW-1:0] sample;
    logic [StatusW-1:0] status;
  } front_t;

  typedef struct packed {
    logic                     force_temp;
    logic signed [TempW-1:0]  temp;
    logic [StatusW-1:0]       status;
  } side_t;

  typedef struct packed {
    logic signed [TempW-1:0] temp_centi;
    logic [StatusW-1:0]      status;
  } result_t;

endpackage

// ===== src/ntc_if.sv =====
// ----------------------------------------------------------------------------
// ntc_if
// Valid/ready channels of the converter: sample in, result out, config write.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
interface ntc_in_if;
  logic                         valid;
  logic                         ready;
  logic [ntc_pkg::SampleW-1:0]  sample_mv;
  modport source (output valid, output sample_mv, input ready);
  modport sink   (input valid, input sample_mv, output ready);
endinterface

interface ntc_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [ntc_pkg::TempW-1:0]   temp_centi;
  logic [ntc_pkg::StatusW-1:0]        status;
  modport source (output valid, output temp_centi, output status, input ready);
  modport sink   (input valid, input temp_centi, input status, output ready);
endinterface

interface ntc_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [ntc_pkg::CfgIdxW-1:0]   index;
  logic [ntc_pkg::CfgDataW-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== src/ntc_front.sv =====
// ----------------------------------------------------------------------------
// ntc_front
// Limit check and divider resistance numerator, two register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ntc_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [ntc_pkg::SampleW-1:0]  in_sample,
  input  ntc_pkg::cfg_t                cfg,
  output logic                         out_valid,
  output ntc_pkg::front_t              out_data
);
  import ntc_pkg::*;

  logic               v1_r, v2_r;
  logic [SampleW-1:0] s1_r;
  logic               oor1_r;
  logic [32:0]        pa1_r;
  logic [33:0]        pb1_r;
  front_t             f2_r;

  logic [32:0]        pa1_nxt;
  logic [33:0]        pb1_nxt;
  logic               oor1_nxt;
  logic signed [34:0] rn;
  front_t             f2_nxt;

  always_comb begin
    pa1_nxt  = 33'(cfg.supply_mv) * 33'(cfg.pulldown_ohms);
    pb1_nxt  = 34'(21'(cfg.pullup_ohms) + 21'(cfg.pulldown_ohms)) * 34'(in_sample);
    oor1_nxt = (in_sample == '0) || (in_sample < cfg.low_limit_mv)
               || (in_sample > cfg.high_limit_mv);
  end

  always_comb begin
    rn = $signed({2'b00, pa1_r}) - $signed({1'b0, pb1_r});
    f2_nxt.sample = s1_r;
    f2_nxt.rn_mag = rn[LnInW-1:0];
    priority if (oor1_r) begin
      f2_nxt.status = ST_LIMIT;
    end else if (rn <= 0) begin
      f2_nxt.status = ST_RES;
    end else begin
      f2_nxt.status = ST_OK;
    end
    // keep the log operands sane on flagged words
    if (f2_nxt.status != ST_OK) begin
      f2_nxt.rn_mag = LnInW'(1);
      f2_nxt.sample = SampleW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r   <= in_sample;
      oor1_r <= oor1_nxt;
      pa1_r  <= pa1_nxt;
      pb1_r  <= pb1_nxt;
      f2_r   <= f2_nxt;
    end
  end

  assign out_valid = v2_r;
  assign out_data  = f2_r;

endmodule

// ===== src/ntc_ln.sv =====
// ----------------------------------------------------------------------------
// ntc_ln
// Q16 natural logarithm, three stages: normalise, table position, interpolate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ntc_ln #(
  parameter int ENTRIES = 256
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [ntc_pkg::LnInW-1:0]  x,
  output logic [ntc_pkg::LnW-1:0]    ln_q16
);
  import ntc_pkg::*;

  localparam int IW   = $clog2(ENTRIES);
  localparam int TW   = $clog2(ENTRIES + 1);
  localparam int PW   = $clog2(LnInW);
  localparam int PosW = 33 + IW;

  // shift-and-subtract long division, only evaluated while building the table
  function automatic longint unsigned div_u64(input longint unsigned a,
                                              input longint unsigned b);
    longint unsigned q, r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], a[i]};
      if (r >= b) begin
        r    = r - b;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // ln(1+i/N) = 2*atanh(i/(2N+i)), Q30 series rounded to Q16
  function automatic logic [15:0] ln_entry(input int unsigned i);
    longint unsigned n, y, y2, term, sum;
    n    = longint'(ENTRIES);
    y    = div_u64(longint'(i) << 30, 2 * n + longint'(i));
    y2   = (y * y) >> 30;
    term = y;
    sum  = 0;
    for (int k = 0; k < 20; k++) begin
      sum  = sum + div_u64(term, longint'(2 * k + 1));
      term = (term * y2) >> 30;
    end
    return 16'((2 * sum + (64'd1 << 13)) >> 14);
  endfunction

  logic [15:0] tab_w [0:ENTRIES];

  for (genvar gi = 0; gi <= ENTRIES; gi++) begin : g_tab
    localparam logic [15:0] Val = ln_entry(gi);
    assign tab_w[gi] = Val;
  end

  logic [PW-1:0]   p1_r, p1_nxt;
  logic [31:0]     frac1_r, frac1_nxt;
  logic [IW-1:0]   idx2_r;
  logic [31:0]     rem2_r;
  logic [LnW-1:0]  pl2_r;
  logic [LnW-1:0]  ln3_r;

  logic [LnInW+31:0] shifted;
  logic [PosW-1:0]   pos;
  logic [39:0]       pl2_full;
  logic [TW-1:0]     idx_lo, idx_hi;
  logic [15:0]       ta, tb, diff;
  logic [47:0]       prod;
  logic [LnW-1:0]    ln3_nxt;

  always_comb begin
    p1_nxt = '0;
    for (int b = 0; b < LnInW; b++) begin
      if (x[b]) p1_nxt = PW'(b);
    end
    shifted   = {x, 32'b0} >> p1_nxt;
    frac1_nxt = shifted[31:0];
  end

  always_comb begin
    pos      = PosW'(frac1_r) * PosW'(ENTRIES);
    pl2_full = 40'(p1_r) * 40'(LN2_Q32) + 40'd32768;
  end

  always_comb begin
    idx_lo  = TW'(idx2_r);
    idx_hi  = idx_lo + TW'(1);
    ta      = tab_w[idx_lo];
    tb      = tab_w[idx_hi];
    diff    = tb - ta;
    prod    = 48'(diff) * 48'(rem2_r) + 48'h0000_8000_0000;
    ln3_nxt = pl2_r + LnW'(ta) + LnW'(prod[47:32]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= p1_nxt;
      frac1_r <= frac1_nxt;
      idx2_r  <= pos[32 +: IW];
      rem2_r  <= pos[31:0];
      pl2_r   <= pl2_full[36:16];
      ln3_r   <= ln3_nxt;
    end
  end

  assign ln_q16 = ln3_r;

endmodule

// ===== src/ntc_div.sv =====
// ----------------------------------------------------------------------------
// ntc_div
// Pipelined restoring divider, one quotient bit a stage, with Celsius offset
// and hot-end saturation in the last stage.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module ntc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [ntc_pkg::NumW-1:0]  in_num,
  input  logic [ntc_pkg::DW-1:0]    in_den,
  input  ntc_pkg::side_t            in_side,
  output logic                      out_valid,
  output ntc_pkg::result_t          out_res
);
  import ntc_pkg::*;

  localparam int CmpW = DW + QW;

  logic            v_r   [0:QW];
  logic [NumW-1:0] rem_r [0:QW];
  logic [QW-1:0]   q_r   [0:QW];
  logic [DW-1:0]   den_r [0:QW];
  logic            ovf_r [0:QW];
  side_t           side_r[0:QW];

  logic            outv_r;
  result_t         res_r, res_nxt;
  logic signed [QW+1:0] t_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= in_num;
      q_r[0]    <= '0;
      den_r[0]  <= in_den;
      ovf_r[0]  <= CmpW'(in_num) >= (CmpW'(in_den) << QW);
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_bit
    localparam int B = QW - k;
    logic [CmpW-1:0] trial, rem_ext;
    logic            take;
    always_comb begin
      trial   = CmpW'(den_r[k-1]) << B;
      rem_ext = CmpW'(rem_r[k-1]);
      take    = rem_ext >= trial;
    end
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= take ? NumW'(rem_ext - trial) : rem_r[k-1];
        q_r[k]    <= q_r[k-1] | (take ? (QW'(1) << B) : '0);
        den_r[k]  <= den_r[k-1];
        ovf_r[k]  <= ovf_r[k-1];
        side_r[k] <= side_r[k-1];
      end
    end
  end

  always_comb begin
    t_raw          = $signed({2'b00, q_r[QW]}) - KELVIN_OFS;
    res_nxt.status = side_r[QW].status;
    priority if (side_r[QW].force_temp) begin
      res_nxt.temp_centi = side_r[QW].temp;
    end else if (ovf_r[QW] || (t_raw > (QW+2)'(TEMP_TOP))) begin
      res_nxt.temp_centi = TEMP_TOP;
    end else begin
      res_nxt.temp_centi = t_raw[TempW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outv_r <= 1'b0;
    end else if (en) begin
      outv_r <= v_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  assign out_valid = outv_r;
  assign out_res   = res_r;

endmodule

// ===== src/ntc_beta_temperature.sv =====
// ----------------------------------------------------------------------------
// ntc_beta_temperature
// Thermistor divider millivolts to hundredths of a degree Celsius.
// ----------------------------------------------------------------------------
// One sample word is taken every cycle unless the skid word holds the pipeline;
// each result is offered on the output after passing through 29 register
// stages (limit check and resistance numerator 2, three parallel 3-stage log
// units 3, log sum, scaling and denominator 3, divider range check plus one
// stage per quotient bit 19, divider result register 1, output register 1).
// The output register and a one-word skid stage decouple the sink, so the
// pipeline only holds when both are full. Configuration writes are always
// ready and take effect at once.
`timescale 1ns / 1ps
module ntc_beta_temperature #(
  parameter int LOG_TABLE_ENTRIES = 256
) (
  input  logic       clk,
  input  logic       rst_n,
  ntc_in_if.sink     in_ch,
  ntc_out_if.source  out_ch,
  ntc_cfg_if.sink    cfg_ch
);
  import ntc_pkg::*;
  `include "ntc_beta_temperature_macros.svh"

  // configuration
  logic [PullupW-1:0]   pullup_r;
  logic [PulldownW-1:0] pulldown_r;
  logic [SupplyW-1:0]   supply_r;
  logic [NominalW-1:0]  nominal_r;
  logic [BetaW-1:0]     beta_r;
  logic [LimitW-1:0]    low_r, high_r;
  cfg_t                 cfg;
  logic [NominalW-1:0]  r0;
  logic [BetaW-1:0]     beta_eff;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pullup_r   <= 20'd8200;
      pulldown_r <= 20'd200000;
      supply_r   <= 13'd3300;
      nominal_r  <= 24'd100000;
      beta_r     <= 14'd3950;
      low_r      <= 13'd100;
      high_r     <= 13'd3200;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_PULLUP:   pullup_r   <= cfg_ch.data[PullupW-1:0];
        REG_PULLDOWN: pulldown_r <= cfg_ch.data[PulldownW-1:0];
        REG_SUPPLY:   supply_r   <= cfg_ch.data[SupplyW-1:0];
        REG_NOMINAL:  nominal_r  <= cfg_ch.data[NominalW-1:0];
        REG_BETA:     beta_r     <= cfg_ch.data[BetaW-1:0];
        REG_LOW:      low_r      <= cfg_ch.data[LimitW-1:0];
        REG_HIGH:     high_r     <= cfg_ch.data[LimitW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.pullup_ohms   = pullup_r;
    cfg.pulldown_ohms = pulldown_r;
    cfg.supply_mv     = supply_r;
    cfg.low_limit_mv  = low_r;
    cfg.high_limit_mv = high_r;
    r0       = (nominal_r == '0) ? NominalW'(1) : nominal_r;
    beta_eff = (beta_r == '0) ? BetaW'(1) : beta_r;
  end

  // pipeline advance: hold only while the skid word is occupied
  logic en;
  logic skid_valid_r, out_valid_r;
  result_t skid_r, out_res_r;

  assign en          = !skid_valid_r;
  assign in_ch.ready = en;

  // front end
  logic   fv;
  front_t fd;

  ntc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_ch.valid),
    .in_sample (in_ch.sample_mv),
    .cfg       (cfg),
    .out_valid (fv),
    .out_data  (fd)
  );

  // three logarithms side by side
  logic [LnW-1:0] ln_rn, ln_s, ln_r0;

  ntc_ln #(.ENTRIES(LOG_TABLE_ENTRIES)) u_ln_rn (
    .clk(clk), .en(en), .x(fd.rn_mag), .ln_q16(ln_rn)
  );
  ntc_ln #(.ENTRIES(LOG_TABLE_ENTRIES)) u_ln_s (
    .clk(clk), .en(en), .x(LnInW'(fd.sample)), .ln_q16(ln_s)
  );
  ntc_ln #(.ENTRIES(LOG_TABLE_ENTRIES)) u_ln_r0 (
    .clk(clk), .en(en), .x(LnInW'(r0)), .ln_q16(ln_r0)
  );

  logic               vl_r  [0:2];
  logic [StatusW-1:0] stl_r [0:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) vl_r[i] <= 1'b0;
    end else if (en) begin
      vl_r[0] <= fv;
      vl_r[1] <= vl_r[0];
      vl_r[2] <= vl_r[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stl_r[0] <= fd.status;
      stl_r[1] <= stl_r[0];
      stl_r[2] <= stl_r[1];
    end
  end

  // log sum, scaling products, denominator
  logic                   vq_r, vm_r, vd_r;
  logic [StatusW-1:0]     stq_r, stm_r;
  logic signed [LqW-1:0]  lq_r, lq_nxt;
  logic signed [DW-1:0]   m1_r, m2_r, m1_nxt, m2_nxt;
  logic [M3W-1:0]         m3_r, m3_nxt;
  logic signed [DW-1:0]   d;
  logic [NumW-1:0]        nn_r, nn_nxt;
  logic [DW-1:0]          dd_r, dd_nxt;
  side_t                  side_r, side_nxt;

  always_comb begin
    lq_nxt = $signed({2'b00, ln_rn}) - $signed({2'b00, ln_s}) - $signed({2'b00, ln_r0});
    m1_nxt = $signed(DW'(37'(23'd6553600) * 37'(beta_eff)));
    m2_nxt = DW'(lq_r) * $signed(40'sd29815);
    m3_nxt = M3W'(22'd2981500) * M3W'(beta_eff);
  end

  always_comb begin
    d      = m1_r + m2_r;
    nn_nxt = NumW'({m3_r, 17'b0}) + NumW'(d);
    dd_nxt = {d[DW-2:0], 1'b0};
    side_nxt.status = stm_r;
    side_nxt.force_temp = (stm_r != ST_OK) || (d <= 0);
    unique case (stm_r)
      ST_LIMIT: side_nxt.temp = TEMP_LIMIT;
      ST_RES:   side_nxt.temp = TEMP_ZERO;
      default:  side_nxt.temp = TEMP_TOP;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vq_r <= 1'b0;
      vm_r <= 1'b0;
      vd_r <= 1'b0;
    end else if (en) begin
      vq_r <= vl_r[2];
      vm_r <= vq_r;
      vd_r <= vm_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stq_r  <= stl_r[2];
      lq_r   <= lq_nxt;
      stm_r  <= stq_r;
      m1_r   <= m1_nxt;
      m2_r   <= m2_nxt;
      m3_r   <= m3_nxt;
      nn_r   <= nn_nxt;
      dd_r   <= dd_nxt;
      side_r <= side_nxt;
    end
  end

  // divider
  logic    pv;
  result_t pres;

  ntc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (vd_r),
    .in_num    (nn_r),
    .in_den    (dd_r),
    .in_side   (side_r),
    .out_valid (pv),
    .out_res   (pres)
  );

  // output register and skid word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (out_ch.ready) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (pv) begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_ch.ready) out_res_r <= skid_r;
    end else if (pv) begin
      if (!out_valid_r || out_ch.ready) begin
        out_res_r <= pres;
      end else begin
        skid_r <= pres;
      end
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.temp_centi = out_res_r.temp_centi;
  assign out_ch.status     = out_res_r.status;

  `NTC_ASSERT_IMPL(a_skid_behind_out, skid_valid_r, out_valid_r)
  `NTC_ASSERT_NEXT(a_skid_holds, skid_valid_r && !out_ch.ready, skid_valid_r && !in_ch.ready)
  `NTC_ASSERT_IMPL(a_limit_temp, out_valid_r && (out_res_r.status == ST_LIMIT), out_res_r.temp_centi == TEMP_LIMIT)
  `NTC_ASSERT_IMPL(a_res_temp, out_valid_r && (out_res_r.status == ST_RES), out_res_r.temp_centi == TEMP_ZERO)

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the thermistor divider to temperature converter.
// Drives sample words through several register settings, predicts each result
// in fixed point and compares temperature and status in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb;
  import ntc_pkg::*;

  localparam int LnEntries = 256;
  localparam int PipeDrain = 40;
  localparam int CycleLimit = 400000;
  localparam int NumPhases = 12;
  localparam int WordsPerPhase = 75;
  localparam int HoldCycles = 300;

  typedef struct {
    logic [SampleW-1:0] sample;
    bit                 typed;
    result_t            want;
  } drow_t;

  logic clk;
  logic rst_n;

  ntc_in_if  in_ch ();
  ntc_out_if out_ch ();
  ntc_cfg_if cfg_ch ();

  ntc_beta_temperature i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // register copy for the predictor
  bit [PullupW-1:0]   pullup_ohms;
  bit [PulldownW-1:0] pulldown_ohms;
  bit [SupplyW-1:0]   supply_mv;
  bit [NominalW-1:0]  nominal_ohms;
  bit [BetaW-1:0]     beta_kelvin;
  bit [LimitW-1:0]    low_limit_mv;
  bit [LimitW-1:0]    high_limit_mv;

  longint unsigned ln_rom [LnEntries+1];
  result_t pending_temps [$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  function automatic void build_ln_rom();
    longint unsigned n, y, y2, term, sum;
    n = LnEntries;
    for (longint unsigned i = 0; i <= n; i++) begin
      y = (i << 30) / (2 * n + i);
      y2 = (y * y) >> 30;
      term = y;
      sum = 0;
      for (longint unsigned k = 0; k < 20; k++) begin
        sum += term / (2 * k + 1);
        term = (term * y2) >> 30;
      end
      ln_rom[i] = (2 * sum + (64'd1 << 13)) >> 14;
    end
  endfunction

  // natural log in Q16
  function automatic longint ln_q16(input longint unsigned x);
    longint unsigned p, frac, pos, idx, rem, a, b, interp;
    p = 0;
    while (p < 63 && (x >> (p + 1)) != 0) p++;
    if (p <= 32) frac = (x << (32 - p)) - (64'd1 << 32);
    else frac = (x >> (p - 32)) - (64'd1 << 32);
    pos = frac * LnEntries;
    idx = pos >> 32;
    rem = pos & 64'hFFFF_FFFF;
    if (idx >= LnEntries) begin
      idx = LnEntries - 1;
      rem = 64'hFFFF_FFFF;
    end
    a = ln_rom[idx];
    b = ln_rom[idx + 1];
    interp = a + (((b - a) * rem + (64'd1 << 31)) >> 32);
    return longint'((p * LN2_Q32 + (64'd1 << 15)) >> 16) + longint'(interp);
  endfunction

  function automatic result_t convert_sample(input logic [SampleW-1:0] s);
    result_t r;
    longint rn, lq, d, b, num, q, t;
    longint unsigned r0;
    if (s == 0 || s < low_limit_mv || s > high_limit_mv) begin
      r.temp_centi = TEMP_LIMIT;
      r.status = ST_LIMIT;
      return r;
    end
    rn = longint'(supply_mv) * longint'(pulldown_ohms)
       - (longint'(pullup_ohms) + longint'(pulldown_ohms)) * longint'(s);
    if (rn <= 0) begin
      r.temp_centi = TEMP_ZERO;
      r.status = ST_RES;
      return r;
    end
    r0 = (nominal_ohms != 0) ? nominal_ohms : 1;
    b = (beta_kelvin != 0) ? longint'(beta_kelvin) : 1;
    lq = ln_q16(rn) - ln_q16(s) - ln_q16(r0);
    d = 64'sd6553600 * b + 64'sd29815 * lq;
    r.status = ST_OK;
    if (d <= 0) begin
      r.temp_centi = TEMP_TOP;
    end else begin
      num = 64'sd2981500 * b * 64'sd65536;
      q = (2 * num + d) / (2 * d);
      t = q - 27315;
      if (t > 200000) t = 200000;
      r.temp_centi = t[TempW-1:0];
    end
    return r;
  endfunction

  function automatic void apply_reg(input logic [CfgIdxW-1:0] idx,
                                    input logic [CfgDataW-1:0] val);
    case (idx)
      REG_PULLUP:   pullup_ohms = val[PullupW-1:0];
      REG_PULLDOWN: pulldown_ohms = val[PulldownW-1:0];
      REG_SUPPLY:   supply_mv = val[SupplyW-1:0];
      REG_NOMINAL:  nominal_ohms = val[NominalW-1:0];
      REG_BETA:     beta_kelvin = val[BetaW-1:0];
      REG_LOW:      low_limit_mv = val[LimitW-1:0];
      REG_HIGH:     high_limit_mv = val[LimitW-1:0];
      default: ;
    endcase
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    bit took;
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= val;
    do begin
      @(negedge clk);
      took = cfg_ch.ready;
      @(posedge clk);
    end while (!took);
    apply_reg(idx, val);
    cfg_ch.valid <= 1'b0;
  endtask

  // offer one sample word, honouring the idle rate; leaves valid high
  task automatic send_sample(input logic [SampleW-1:0] s, input bit typed, input result_t want);
    bit took;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.sample_mv <= s;
    do begin
      @(negedge clk);
      took = in_ch.ready;
      @(posedge clk);
    end while (!took);
    pending_temps.push_back(typed ? want : convert_sample(s));
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_temps.size() != 0) @(posedge clk);
    repeat (PipeDrain) @(posedge clk);
  endtask

  function automatic logic [SampleW-1:0] pick_sample();
    longint unsigned sb, lo, hi;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) return $urandom_range(0, 8191);
    if (roll < 25 && (longint'(pullup_ohms) + pulldown_ohms) != 0) begin
      // hover around the point where the thermistor resistance reaches zero
      sb = longint'(supply_mv) * pulldown_ohms / (longint'(pullup_ohms) + pulldown_ohms);
      sb = sb + $urandom_range(0, 40);
      sb = (sb > 20) ? sb - 20 : 1;
      return (sb > 8191) ? 13'd8191 : sb[SampleW-1:0];
    end
    if (low_limit_mv > high_limit_mv) return $urandom_range(0, 8191);
    lo = (low_limit_mv == 0) ? 1 : low_limit_mv;
    hi = high_limit_mv;
    if (lo > hi) return $urandom_range(0, 8191);
    return $urandom_range(hi, lo);
  endfunction

  task automatic load_setting(input int ph);
    logic [CfgDataW-1:0] v [7];
    case (ph)
      1: v = '{1000000, 1000000, 5000, 10000000, 10000, 0, 5000};
      2: v = '{0, 1, 1, 1, 1, 0, 8191};
      3: v = '{0, 0, 0, 0, 0, 0, 8191};
      4: v = '{8200, 200000, 3300, 100000, 3950, 3000, 2000};
      5: v = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
               24'hFFFFFF};
      6: v = '{10000, 10000, 3300, 10000, 3435, 1, 3300};
      11: v = '{8200, 200000, 3300, 100000, 3950, 100, 3200};
      default: begin
        v[0] = $urandom_range(0, 1000000);
        v[1] = $urandom_range(1, 1000000);
        v[2] = $urandom_range(1, 5000);
        v[3] = $urandom_range(1, 10000000);
        v[4] = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10000) : $urandom_range(2000, 5000);
        v[5] = $urandom_range(0, 300);
        v[6] = $urandom_range(2000, 5000);
      end
    endcase
    write_reg(REG_PULLUP, v[0]);
    write_reg(REG_PULLDOWN, v[1]);
    write_reg(REG_SUPPLY, v[2]);
    write_reg(REG_NOMINAL, v[3]);
    write_reg(REG_BETA, v[4]);
    write_reg(REG_LOW, v[5]);
    write_reg(REG_HIGH, v[6]);
  endtask

  // receiver: random stall, or a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst_n) begin
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
      end
    end
  end

  always @(negedge clk) begin
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_temps.size() == 0) begin
        report("unexpected word", out_ch.temp_centi, 0);
      end else begin
        want = pending_temps.pop_front();
        if (out_ch.temp_centi !== want.temp_centi)
          report("temp_centi", out_ch.temp_centi, want.temp_centi);
        if (out_ch.status !== want.status)
          report("status", out_ch.status, want.status);
      end
    end
  end

  initial begin
    drow_t rows [$];
    result_t none;
    none = '0;
    rows = '{
      '{13'd0,    1'b1, '{TEMP_LIMIT, ST_LIMIT}},
      '{13'd1,    1'b1, '{TEMP_LIMIT, ST_LIMIT}},
      '{13'd99,   1'b1, '{TEMP_LIMIT, ST_LIMIT}},
      '{13'd3201, 1'b1, '{TEMP_LIMIT, ST_LIMIT}},
      '{13'd4096, 1'b1, '{TEMP_LIMIT, ST_LIMIT}},
      '{13'd5461, 1'b1, '{TEMP_LIMIT, ST_LIMIT}},
      '{13'd8191, 1'b1, '{TEMP_LIMIT, ST_LIMIT}},
      '{13'd3200, 1'b1, '{TEMP_ZERO, ST_RES}},
      '{13'd3190, 1'b1, '{TEMP_ZERO, ST_RES}},
      '{13'd100,  1'b0, none},
      '{13'd101,  1'b0, none},
      '{13'd500,  1'b0, none},
      '{13'd1650, 1'b0, none},
      '{13'd2000, 1'b0, none},
      '{13'd2730, 1'b0, none},
      '{13'd3169, 1'b0, none},
      '{13'd3170, 1'b0, none}
    };
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.sample_mv <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_PULLUP;
    cfg_ch.data <= '0;
    build_ln_rom();
    apply_reg(REG_PULLUP, 8200);
    apply_reg(REG_PULLDOWN, 200000);
    apply_reg(REG_SUPPLY, 3300);
    apply_reg(REG_NOMINAL, 100000);
    apply_reg(REG_BETA, 3950);
    apply_reg(REG_LOW, 100);
    apply_reg(REG_HIGH, 3200);
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_sample(rows[i].sample, rows[i].typed, rows[i].want);

    for (int ph = 0; ph < NumPhases; ph++) begin
      if (ph != 0) begin
        drain();
        load_setting(ph);
      end
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 78; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 78; end
        default: begin idle_pct = 34; stall_pct = 34; end
      endcase
      // long receiver hold while words keep coming, so the input backs up
      if (ph == 4 || ph == 8) begin
        idle_pct = 0;
        hold_req = 1'b1;
      end
      for (int n = 0; n < WordsPerPhase; n++) begin
        // stop offering until everything has come out
        if (ph == 2 && n == WordsPerPhase / 2) begin
          in_ch.valid <= 1'b0;
          while (pending_temps.size() != 0) @(posedge clk);
        end
        send_sample(pick_sample(), 1'b0, none);
      end
    end

    drain();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
